>>> hdl/dchd_pkg.sv
// ----------------------------------------------------------------------------
// dchd_pkg
// Types and constants shared by the debounce / click / hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dchd_pkg;

  localparam int unsigned WORK_QUEUE_DEPTH   = 2;
  localparam int unsigned RESULT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  source_id;
    logic [15:0] sample_bits;
    logic [15:0] elapsed_ms;
  } dchd_sample_t;

  typedef enum logic [1:0] {
    EV_LOW    = 2'd0,
    EV_HIGH   = 2'd1,
    EV_CLICKS = 2'd2,
    EV_HOLD   = 2'd3
  } dchd_event_t;

  typedef struct packed {
    logic [7:0]  bank_id;
    logic [3:0]  input_index;
    logic        is_button;
    dchd_event_t event_kind;
    logic [2:0]  click_count;
    logic        last_event;
  } dchd_result_t;

  // sample after inversion: bit set means the input is low (active)
  typedef struct packed {
    logic [7:0]  bank;
    logic [15:0] low_bits;
    logic [15:0] elapsed;
  } dchd_work_t;

  typedef struct packed {
    logic [15:0] button_mask;
    logic [15:0] button_press_debounce;
    logic [15:0] button_release_debounce;
    logic [15:0] switch_low_debounce;
    logic [15:0] switch_high_debounce;
    logic [15:0] hold_time;
    logic [15:0] multi_click_gap;
  } dchd_cfg_t;

  typedef enum logic [2:0] {
    REG_BUTTON_MASK     = 3'd0,
    REG_INVERT_MASK     = 3'd1,
    REG_BUTTON_PRESS    = 3'd2,
    REG_BUTTON_RELEASE  = 3'd3,
    REG_SWITCH_LOW      = 3'd4,
    REG_SWITCH_HIGH     = 3'd5,
    REG_HOLD_TIME       = 3'd6,
    REG_MULTI_CLICK_GAP = 3'd7
  } dchd_reg_t;

  typedef enum logic [2:0] {
    ST_HIGH     = 3'd0,
    ST_DEB_LOW  = 3'd1,
    ST_LOW      = 3'd2,
    ST_DEB_HIGH = 3'd3,
    ST_AWAIT    = 3'd4
  } dchd_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_FLUSH
  } dchd_phase_t;

endpackage

`default_nettype wire

>>> hdl/debounce_click_hold_detector_top.sv
// ----------------------------------------------------------------------------
// debounce_click_hold_detector_top
// Debounce, multi-click and hold detection for a bank of active-low inputs.
// ----------------------------------------------------------------------------
// Each accepted sample goes into a two-entry sample queue; the engine then
// loads it, updates one input per cycle through a single shared debounce
// unit and closes out the sample by tagging its last event. Events leave
// through a four-entry result queue in increasing input order; the engine
// pauses while that queue is full. Writing button_mask releases every input
// at once; timers are kept.
`default_nettype none

module debounce_click_hold_detector_top #(
  parameter int unsigned NUM_INPUTS = 16,
  parameter int unsigned MAX_CLICKS = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire dchd_pkg::dchd_sample_t sample,
  output logic                        full,
  output logic                        empty,
  input  wire logic                   pop,
  output dchd_pkg::dchd_result_t      result,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);

  import dchd_pkg::*;

  dchd_cfg_t    cfg;
  logic [15:0]  invert_mask;
  logic         release_all;

  logic         wq_push;
  dchd_work_t   wq_wdata;
  logic         wq_full;
  logic         wq_pop;
  dchd_work_t   wq_rdata;
  logic         wq_empty;

  logic         rq_push;
  dchd_result_t rq_wdata;
  logic         rq_full;

  assign release_all = cfg_we && dchd_reg_t'(cfg_index) == REG_BUTTON_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_mask             <= 16'd0;
      invert_mask                 <= 16'd0;
      cfg.button_press_debounce   <= 16'd10;
      cfg.button_release_debounce <= 16'd10;
      cfg.switch_low_debounce     <= 16'd20;
      cfg.switch_high_debounce    <= 16'd20;
      cfg.hold_time               <= 16'd500;
      cfg.multi_click_gap         <= 16'd250;
    end else if (cfg_we) begin
      unique case (dchd_reg_t'(cfg_index))
        REG_BUTTON_MASK:     cfg.button_mask             <= cfg_data;
        REG_INVERT_MASK:     invert_mask                 <= cfg_data;
        REG_BUTTON_PRESS:    cfg.button_press_debounce   <= cfg_data;
        REG_BUTTON_RELEASE:  cfg.button_release_debounce <= cfg_data;
        REG_SWITCH_LOW:      cfg.switch_low_debounce     <= cfg_data;
        REG_SWITCH_HIGH:     cfg.switch_high_debounce    <= cfg_data;
        REG_HOLD_TIME:       cfg.hold_time               <= cfg_data;
        REG_MULTI_CLICK_GAP: cfg.multi_click_gap         <= cfg_data;
        default: ;
      endcase
    end
  end

  dchd_front u_front (
    .push        (push),
    .sample      (sample),
    .full        (full),
    .invert_mask (invert_mask),
    .q_full      (wq_full),
    .q_push      (wq_push),
    .q_data      (wq_wdata)
  );

  dchd_fifo #(
    .W     ($bits(dchd_work_t)),
    .DEPTH (WORK_QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wq_push),
    .wr_data (wq_wdata),
    .full    (wq_full),
    .rd_en   (wq_pop),
    .rd_data (wq_rdata),
    .empty   (wq_empty)
  );

  dchd_engine #(
    .NUM_INPUTS (NUM_INPUTS),
    .MAX_CLICKS (MAX_CLICKS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .release_all (release_all),
    .work_empty  (wq_empty),
    .work_data   (wq_rdata),
    .work_pop    (wq_pop),
    .res_full    (rq_full),
    .res_push    (rq_push),
    .res_data    (rq_wdata)
  );

  dchd_fifo #(
    .W     ($bits(dchd_result_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rq_push),
    .wr_data (rq_wdata),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

`default_nettype wire

>>> hdl/dchd_fifo.sv
// ----------------------------------------------------------------------------
// dchd_fifo
// Small synchronous queue with full / empty flags and a show-ahead read.
// ----------------------------------------------------------------------------
`default_nettype none

module dchd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/dchd_front.sv
// ----------------------------------------------------------------------------
// dchd_front
// Accepts samples, applies the inversion mask and queues them as active-low
// level bits for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dchd_front (
  input  wire logic                  push,
  input  wire dchd_pkg::dchd_sample_t sample,
  output logic                       full,
  input  wire logic [15:0]           invert_mask,
  input  wire logic                  q_full,
  output logic                       q_push,
  output dchd_pkg::dchd_work_t       q_data
);

  import dchd_pkg::*;

  assign full            = q_full;
  assign q_push          = push && !q_full;
  assign q_data.bank     = sample.source_id;
  assign q_data.low_bits = ~(sample.sample_bits ^ invert_mask);
  assign q_data.elapsed  = sample.elapsed_ms;

endmodule

`default_nettype wire

>>> hdl/dchd_engine.sv
// ----------------------------------------------------------------------------
// dchd_engine
// Walks the inputs of one queued sample, one input per cycle while the
// result queue has room, through the shared debounce update and pushes the
// resulting events. One event is held back to tag a sample's final one.
// ----------------------------------------------------------------------------
`default_nettype none

module dchd_engine #(
  parameter int unsigned NUM_INPUTS = 16,
  parameter int unsigned MAX_CLICKS = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dchd_pkg::dchd_cfg_t  cfg,
  input  wire logic                 release_all,
  input  wire logic                 work_empty,
  input  wire dchd_pkg::dchd_work_t work_data,
  output logic                      work_pop,
  input  wire logic                 res_full,
  output logic                      res_push,
  output dchd_pkg::dchd_result_t    res_data
);

  import dchd_pkg::*;

  localparam int unsigned IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

  dchd_phase_t  phase;
  dchd_phase_t  phase_next;
  logic [IW-1:0] idx;
  dchd_work_t   work;
  dchd_result_t hold_ev;
  logic         hold_valid;

  dchd_state_t  st    [NUM_INPUTS];
  logic [2:0]   tally [NUM_INPUTS];
  logic         held  [NUM_INPUTS];
  logic [15:0]  timer [NUM_INPUTS];

  logic [NUM_INPUTS-1:0] lows;
  logic [NUM_INPUTS-1:0] buttons;

  logic          step;
  logic          load;
  logic          flush_push;
  logic          button;
  logic          low;
  logic [15:0]   low_deb;
  logic [15:0]   high_deb;
  logic [16:0]   tsum;
  logic [15:0]   tsat;
  dchd_state_t   st_next;
  logic [2:0]    tally_next;
  logic          held_next;
  logic [15:0]   timer_next;
  logic          ev_valid;
  dchd_event_t   ev_kind;
  logic [2:0]    ev_clicks;
  dchd_result_t  new_ev;

  assign lows    = work.low_bits[NUM_INPUTS-1:0];
  assign buttons = cfg.button_mask[NUM_INPUTS-1:0];

  // per-input update
  always_comb begin
    button   = buttons[idx];
    low      = lows[idx];
    low_deb  = button ? cfg.button_press_debounce : cfg.switch_low_debounce;
    high_deb = button ? cfg.button_release_debounce : cfg.switch_high_debounce;
    tsum     = {1'b0, timer[idx]} + {1'b0, work.elapsed};
    tsat     = tsum[16] ? 16'hFFFF : tsum[15:0];
    st_next    = st[idx];
    tally_next = tally[idx];
    held_next  = held[idx];
    timer_next = tsat;
    ev_valid  = 1'b0;
    ev_kind   = EV_LOW;
    ev_clicks = 3'd0;
    unique case (st[idx])
      ST_DEB_LOW: begin
        if (!low) begin
          st_next    = ST_HIGH;
          timer_next = '0;
        end else if (tsat > low_deb) begin
          st_next    = ST_LOW;
          timer_next = '0;
          if (!button) begin
            ev_valid = 1'b1;
            ev_kind  = EV_LOW;
          end
        end
      end
      ST_LOW: begin
        if (!low) begin
          st_next    = ST_DEB_HIGH;
          timer_next = '0;
        end else if (button && tsat > cfg.hold_time) begin
          held_next  = 1'b1;
          timer_next = '0;
          ev_valid   = 1'b1;
          ev_kind    = EV_HOLD;
        end
      end
      ST_DEB_HIGH: begin
        if (low) begin
          st_next    = ST_LOW;
          timer_next = '0;
        end else if (tsat > high_deb) begin
          if (!button) begin
            st_next    = ST_HIGH;
            timer_next = '0;
            ev_valid   = 1'b1;
            ev_kind    = EV_HIGH;
          end else if (held[idx]) begin
            st_next = ST_HIGH;
          end else begin
            if (tally[idx] < 3'(MAX_CLICKS)) begin
              tally_next = tally[idx] + 3'd1;
            end
            st_next    = ST_AWAIT;
            timer_next = '0;
          end
        end
      end
      ST_AWAIT: begin
        if (low) begin
          st_next    = ST_DEB_LOW;
          timer_next = '0;
        end else if (tsat > cfg.multi_click_gap) begin
          st_next   = ST_HIGH;
          ev_valid  = 1'b1;
          ev_kind   = EV_CLICKS;
          ev_clicks = tally[idx];
        end
      end
      default: begin
        st_next    = ST_HIGH;
        tally_next = 3'd0;
        held_next  = 1'b0;
        if (low) begin
          st_next    = ST_DEB_LOW;
          timer_next = '0;
        end
      end
    endcase
    new_ev.bank_id     = work.bank;
    new_ev.input_index = 4'(idx);
    new_ev.is_button   = button;
    new_ev.event_kind  = ev_kind;
    new_ev.click_count = ev_clicks;
    new_ev.last_event  = 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    step       = 1'b0;
    load       = 1'b0;
    flush_push = 1'b0;
    work_pop   = 1'b0;
    res_push   = 1'b0;
    res_data   = hold_ev;
    unique case (phase)
      PH_IDLE: begin
        if (!work_empty) begin
          load       = 1'b1;
          work_pop   = 1'b1;
          phase_next = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (!res_full) begin
          step     = 1'b1;
          res_push = ev_valid && hold_valid;
          if (idx == IW'(NUM_INPUTS - 1)) begin
            phase_next = PH_FLUSH;
          end
        end
      end
      PH_FLUSH: begin
        if (!hold_valid) begin
          phase_next = PH_IDLE;
        end else if (!res_full) begin
          flush_push          = 1'b1;
          res_push            = 1'b1;
          res_data.last_event = 1'b1;
          phase_next          = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= work_data;
    end
    if (step && ev_valid) begin
      hold_ev <= new_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= '0;
      end else if (step && idx != IW'(NUM_INPUTS - 1)) begin
        idx <= idx + 1'b1;
      end
      if (step && ev_valid) begin
        hold_valid <= 1'b1;
      end else if (flush_push) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_INPUTS; k++) begin
        st[k]    <= ST_HIGH;
        tally[k] <= 3'd0;
        held[k]  <= 1'b0;
        timer[k] <= '0;
      end
    end else if (release_all) begin
      for (int k = 0; k < NUM_INPUTS; k++) begin
        st[k]    <= ST_HIGH;
        tally[k] <= 3'd0;
        held[k]  <= 1'b0;
      end
    end else if (step) begin
      st[idx]    <= st_next;
      tally[idx] <= tally_next;
      held[idx]  <= held_next;
      timer[idx] <= timer_next;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_last_only_in_flush: assert property (@(posedge clk) disable iff (rst)
    res_push && res_data.last_event |-> phase == PH_FLUSH)
    else $error("last beat tagged outside the flush cycle");

  a_flush_empties_hold: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FLUSH && !res_full |=> phase == PH_IDLE && !hold_valid)
    else $error("held event survived the flush");

  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    work_pop |-> phase == PH_IDLE && !work_empty && !hold_valid)
    else $error("sample taken while the previous one is unfinished");

endmodule

`default_nettype wire
